### hdl/gas_sensor_frame_parser_defines.svh
// Assertion macros used by the verification checker of the frame parser.
`ifndef GAS_SENSOR_FRAME_PARSER_DEFINES_SVH
`define GAS_SENSOR_FRAME_PARSER_DEFINES_SVH

// Check the consequent in the cycle after the antecedent, outside reset.
`define GSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser check failed");

// Check the consequent in the same cycle as the antecedent, outside reset.
`define GSFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame parser check failed");

// Check behavior across reset itself.
`define GSFP_ASSERT_RESET(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("frame parser reset check failed");

`endif

### hdl/gsfp_pkg.sv
`timescale 1ns / 1ps

package gsfp_pkg;

    // Fixed frame bytes
    localparam logic [7:0] START_BYTE   = 8'hFF;
    localparam logic [7:0] COMMAND_BYTE = 8'h86;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;

    // Byte position within the 9-byte frame
    localparam logic [3:0] POS_START    = 4'd0;
    localparam logic [3:0] POS_COMMAND  = 4'd1;
    localparam logic [3:0] POS_GAS      = 4'd2;
    localparam logic [3:0] POS_UNIT     = 4'd3;
    localparam logic [3:0] POS_ZERO_A   = 4'd4;
    localparam logic [3:0] POS_ZERO_B   = 4'd5;
    localparam logic [3:0] POS_CONC_HI  = 4'd6;
    localparam logic [3:0] POS_CONC_LO  = 4'd7;
    localparam logic [3:0] POS_CHECKSUM = 4'd8;

    // One parsed frame
    typedef struct packed {
        logic [15:0] concentration;
        logic [7:0]  unit_code;
        logic [7:0]  gas_code;
    } frame_data_t;

    typedef struct packed {
        frame_data_t data;
        logic        checksum_ok;
    } frame_result_t;

endpackage

### hdl/gas_sensor_frame_parser.sv
// Gas sensor frame parser: takes one received serial byte per input transaction and
// tracks its place in a 9-byte frame (0xFF, 0x86, gas, unit, 0x00, 0x00, conc high,
// conc low, checksum); a mismatch at a checked byte drops the frame and the byte is
// consumed. Each complete frame yields one output transaction with the gas code, unit
// and concentration on m_tdata and the checksum verdict on m_tuser. A byte passes
// through an input register and one compare-and-add step into the result register,
// so a byte can be accepted every cycle unless the output stalls; the result is
// registered as the parser takes the final frame byte from the input register; a
// stalled output holds one result while the input register still takes one more byte.
`timescale 1ns / 1ps

module gas_sensor_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] gas_code, [15:8] unit_code, [31:16] concentration
    output logic        m_tuser    // [0] checksum_ok
);

    logic                    byte_valid;
    logic [7:0]              byte_data;
    logic                    byte_take;
    gsfp_pkg::frame_result_t res_data;

    gsfp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take)
    );

    gsfp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take),
        .res_valid  (m_tvalid),
        .res_data   (res_data),
        .res_ready  (m_tready)
    );

    // Pack result fields onto the stream
    assign m_tdata = res_data.data;
    assign m_tuser = res_data.checksum_ok;

endmodule

### hdl/gsfp_in_reg.sv
`timescale 1ns / 1ps

module gsfp_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    output logic       byte_valid,
    output logic [7:0] byte_data,
    input  logic       byte_take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Accept a new transaction whenever the slot is empty or drains this cycle
    assign s_tready   = !valid_reg || byte_take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !byte_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on every accepted transaction
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

### hdl/gsfp_parser.sv
`timescale 1ns / 1ps

module gsfp_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   byte_valid,
    input  logic [7:0]             byte_data,
    output logic                   byte_take,
    output logic                   res_valid,
    output gsfp_pkg::frame_result_t res_data,
    input  logic                   res_ready
);

    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] sum_add;
    logic [7:0] gas_reg;
    logic [7:0] unit_reg;
    logic [7:0] conc_hi_reg;
    logic [7:0] conc_lo_reg;
    logic       emit;
    logic       out_valid_reg;
    logic       out_valid_next;
    gsfp_pkg::frame_result_t out_data_reg;

    // Take a byte when the result slot is free or being emptied
    assign byte_take = byte_valid && (!out_valid_reg || res_ready);
    assign sum_add   = sum_reg + byte_data;

    // Advance the frame position and running sum
    always_comb begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        emit     = 1'b0;
        unique case (pos_reg)
            gsfp_pkg::POS_COMMAND: begin
                if (byte_data == gsfp_pkg::COMMAND_BYTE) begin
                    sum_next = sum_add;
                    pos_next = gsfp_pkg::POS_GAS;
                end else begin
                    pos_next = gsfp_pkg::POS_START;
                end
            end
            gsfp_pkg::POS_GAS: begin
                sum_next = sum_add;
                pos_next = gsfp_pkg::POS_UNIT;
            end
            gsfp_pkg::POS_UNIT: begin
                sum_next = sum_add;
                pos_next = gsfp_pkg::POS_ZERO_A;
            end
            gsfp_pkg::POS_ZERO_A, gsfp_pkg::POS_ZERO_B: begin
                if (byte_data == gsfp_pkg::ZERO_BYTE) begin
                    sum_next = sum_add;
                    pos_next = pos_reg + 4'd1;
                end else begin
                    pos_next = gsfp_pkg::POS_START;
                end
            end
            gsfp_pkg::POS_CONC_HI: begin
                sum_next = sum_add;
                pos_next = gsfp_pkg::POS_CONC_LO;
            end
            gsfp_pkg::POS_CONC_LO: begin
                sum_next = sum_add;
                pos_next = gsfp_pkg::POS_CHECKSUM;
            end
            gsfp_pkg::POS_CHECKSUM: begin
                sum_next = sum_add;
                emit     = 1'b1;
                pos_next = gsfp_pkg::POS_START;
            end
            // Waiting for start; unused codes behave the same
            default: begin
                if (byte_data == gsfp_pkg::START_BYTE) begin
                    sum_next = 8'd0;
                    pos_next = gsfp_pkg::POS_COMMAND;
                end else begin
                    pos_next = gsfp_pkg::POS_START;
                end
            end
        endcase
    end

    // Hold frame position and sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= gsfp_pkg::POS_START;
            sum_reg <= 8'd0;
        end else if (byte_take) begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Capture payload bytes at their positions
    always_ff @(posedge aclk) begin
        if (byte_take) begin
            if (pos_reg == gsfp_pkg::POS_GAS) begin
                gas_reg <= byte_data;
            end
            if (pos_reg == gsfp_pkg::POS_UNIT) begin
                unit_reg <= byte_data;
            end
            if (pos_reg == gsfp_pkg::POS_CONC_HI) begin
                conc_hi_reg <= byte_data;
            end
            if (pos_reg == gsfp_pkg::POS_CONC_LO) begin
                conc_lo_reg <= byte_data;
            end
        end
    end

    // Result register: fill on emit, drop when taken downstream
    assign out_valid_next = (byte_take && emit) || (out_valid_reg && !res_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_take && emit) begin
            out_data_reg.data.gas_code      <= gas_reg;
            out_data_reg.data.unit_code     <= unit_reg;
            out_data_reg.data.concentration <= {conc_hi_reg, conc_lo_reg};
            out_data_reg.checksum_ok        <= (sum_next == 8'd0);
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

### hdl/gsfp_checker.sv
`timescale 1ns / 1ps
`include "gas_sensor_frame_parser_defines.svh"

module gsfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // No result survives reset
    `GSFP_ASSERT_RESET(a_reset_clears_out, aclk, !aresetn, !m_tvalid)

    // An open output path never stalls the input
    `GSFP_ASSERT_SAME(a_ready_passes, aclk, aresetn, m_tready, s_tready)

    // A stalled result stays put
    `GSFP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A waiting input transaction stays put
    `GSFP_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_tvalid && !s_tready,
                      s_tvalid && $stable(s_tdata))

endmodule

bind gas_sensor_frame_parser gsfp_checker u_gsfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/gas_sensor_frame_parser_tb.sv
`timescale 1ns / 1ps

module gas_sensor_frame_parser_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BYTES  = 1150;
    localparam int CALM_TAIL     = 150;
    localparam int LONG_HOLD     = 250;
    localparam int DRAIN_CYCLES  = 10;
    localparam int MAX_REPORTS   = 10;

    // One row of stimulus: the byte and, where it closes a frame, an optional typed result
    typedef struct packed {
        logic [7:0]              rx_byte;
        logic                    typed;
        gsfp_pkg::frame_result_t want;
    } stim_row_t;

    localparam gsfp_pkg::frame_result_t NO_FRAME = '0;
    localparam gsfp_pkg::frame_result_t ZERO_FRAME_OK = '{
        data: '{concentration: 16'h0000, unit_code: 8'h00, gas_code: 8'h00},
        checksum_ok: 1'b1};
    localparam gsfp_pkg::frame_result_t MAX_FRAME_BAD = '{
        data: '{concentration: 16'hFFFF, unit_code: 8'hFF, gas_code: 8'hFF},
        checksum_ok: 1'b0};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [7:0] gas_code, [15:8] unit_code, [31:16] concentration
    logic        m_tuser;    // [0] checksum_ok

    gas_sensor_frame_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Parser shadow state
    logic [3:0] shadow_pos;
    logic [7:0] shadow_sum;
    logic [7:0] shadow_gas;
    logic [7:0] shadow_unit;
    logic [7:0] shadow_conc_hi;
    logic [7:0] shadow_conc_lo;

    gsfp_pkg::frame_result_t pending_frames[$];
    stim_row_t               stim_q[$];
    stim_row_t               cur_row;

    int  cycle_count;
    int  mismatch_count;
    int  frame_bytes;
    bit  calm_phase;
    bit  long_hold_req;

    bit                      frame_done;
    gsfp_pkg::frame_result_t frame_out;
    gsfp_pkg::frame_result_t frame_want;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Advance the shadow parser by one byte; flag a finished frame
    function automatic void parse_rx_byte(input logic [7:0] b, output bit done,
                                          output gsfp_pkg::frame_result_t frame);
        logic [7:0] sum_next;
        sum_next = shadow_sum + b;
        done = 1'b0;
        frame = NO_FRAME;
        case (shadow_pos)
            gsfp_pkg::POS_COMMAND: begin
                if (b == gsfp_pkg::COMMAND_BYTE) begin
                    shadow_sum = sum_next;
                    shadow_pos = gsfp_pkg::POS_GAS;
                end else begin
                    shadow_pos = gsfp_pkg::POS_START;
                end
            end
            gsfp_pkg::POS_GAS: begin
                shadow_gas = b;
                shadow_sum = sum_next;
                shadow_pos = gsfp_pkg::POS_UNIT;
            end
            gsfp_pkg::POS_UNIT: begin
                shadow_unit = b;
                shadow_sum = sum_next;
                shadow_pos = gsfp_pkg::POS_ZERO_A;
            end
            gsfp_pkg::POS_ZERO_A, gsfp_pkg::POS_ZERO_B: begin
                if (b == gsfp_pkg::ZERO_BYTE) begin
                    shadow_sum = sum_next;
                    shadow_pos = shadow_pos + 4'd1;
                end else begin
                    shadow_pos = gsfp_pkg::POS_START;
                end
            end
            gsfp_pkg::POS_CONC_HI: begin
                shadow_conc_hi = b;
                shadow_sum = sum_next;
                shadow_pos = gsfp_pkg::POS_CONC_LO;
            end
            gsfp_pkg::POS_CONC_LO: begin
                shadow_conc_lo = b;
                shadow_sum = sum_next;
                shadow_pos = gsfp_pkg::POS_CHECKSUM;
            end
            gsfp_pkg::POS_CHECKSUM: begin
                shadow_sum = sum_next;
                frame.data.gas_code = shadow_gas;
                frame.data.unit_code = shadow_unit;
                frame.data.concentration = {shadow_conc_hi, shadow_conc_lo};
                frame.checksum_ok = (sum_next == 8'h00);
                done = 1'b1;
                shadow_pos = gsfp_pkg::POS_START;
            end
            default: begin
                // waiting for start; out-of-range positions behave the same
                if (b == gsfp_pkg::START_BYTE) begin
                    shadow_sum = 8'h00;
                    shadow_pos = gsfp_pkg::POS_COMMAND;
                end else begin
                    shadow_pos = gsfp_pkg::POS_START;
                end
            end
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0d: %s", cycle_count, msg);
    endtask

    // Predict on each input transaction, check each output transaction, watch the clock limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frames outstanding",
                     cycle_count, pending_frames.size());
            $display("FAILURE");
            $finish;
        end
        if (aresetn && s_tvalid && s_tready) begin
            parse_rx_byte(cur_row.rx_byte, frame_done, frame_out);
            if (frame_done)
                pending_frames.push_back(cur_row.typed ? cur_row.want : frame_out);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_frames.size() == 0) begin
                note_mismatch($sformatf("unexpected frame: gas %02h unit %02h conc %04h ok %0d",
                              m_tdata[7:0], m_tdata[15:8], m_tdata[31:16], m_tuser));
            end else begin
                frame_want = pending_frames.pop_front();
                if (m_tdata[7:0] !== frame_want.data.gas_code ||
                    m_tdata[15:8] !== frame_want.data.unit_code ||
                    m_tdata[31:16] !== frame_want.data.concentration ||
                    m_tuser !== frame_want.checksum_ok) begin
                    note_mismatch({
                        $sformatf("frame mismatch: expected gas %02h unit %02h conc %04h ok %0d",
                                  frame_want.data.gas_code, frame_want.data.unit_code,
                                  frame_want.data.concentration, frame_want.checksum_ok),
                        $sformatf(", got gas %02h unit %02h conc %04h ok %0d",
                                  m_tdata[7:0], m_tdata[15:8], m_tdata[31:16], m_tuser)});
                end
            end
        end
    end

    // Output side: random stall bursts, quiet stretches, one long hold-off on request
    initial begin
        int stall_left;
        int hold_left;
        int quiet_left;
        bit quiet;
        stall_left = 0;
        hold_left = 0;
        quiet_left = 0;
        quiet = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (quiet_left == 0) begin
                quiet = ($urandom_range(0, 2) == 0);
                quiet_left = 100;
            end
            quiet_left--;
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (calm_phase || quiet) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Mostly plain values, sometimes an extreme
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return $urandom_range(0, 255);
    endfunction

    task automatic add_byte(input logic [7:0] b);
        stim_q.push_back('{rx_byte: b, typed: 1'b0, want: NO_FRAME});
    endtask

    // Well-formed frame, checksum right or arbitrary
    task automatic add_frame(input bit good_sum);
        logic [7:0] gas;
        logic [7:0] unit;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] sum;
        gas = pick_byte();
        unit = pick_byte();
        hi = pick_byte();
        lo = pick_byte();
        sum = gsfp_pkg::COMMAND_BYTE + gas + unit + hi + lo;
        add_byte(gsfp_pkg::START_BYTE);
        add_byte(gsfp_pkg::COMMAND_BYTE);
        add_byte(gas);
        add_byte(unit);
        add_byte(gsfp_pkg::ZERO_BYTE);
        add_byte(gsfp_pkg::ZERO_BYTE);
        add_byte(hi);
        add_byte(lo);
        add_byte(good_sum ? 8'h00 - sum : pick_byte());
        frame_bytes += 9;
    endtask

    // Frame broken at the command byte or one of the zero bytes
    task automatic add_broken_frame();
        int         break_at;
        logic [7:0] bad;
        break_at = $urandom_range(0, 2);
        add_byte(gsfp_pkg::START_BYTE);
        if (break_at == 0) begin
            do bad = $urandom_range(0, 255); while (bad == gsfp_pkg::COMMAND_BYTE);
            add_byte(bad);
            frame_bytes += 2;
        end else begin
            add_byte(gsfp_pkg::COMMAND_BYTE);
            add_byte(pick_byte());
            add_byte(pick_byte());
            if (break_at == 2)
                add_byte(gsfp_pkg::ZERO_BYTE);
            add_byte($urandom_range(1, 255));
            frame_bytes += 4 + break_at;
        end
    endtask

    // Present one byte, holding it until the input transaction completes
    task automatic send_row(input stim_row_t row, input int gap);
        @(negedge aclk);
        while (gap > 0) begin
            s_tvalid <= 1'b0;
            gap--;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= row.rx_byte;
        cur_row = row;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Input side: reset, directed table, random frames, drain
    initial begin
        stim_row_t directed_rows [25];
        stim_row_t row;
        int        gap;
        int        quiet_left;
        bit        quiet;
        int        sent;
        int        pick;

        directed_rows = '{
            // all-zero payload, correct checksum
            '{8'hFF, 1'b0, NO_FRAME}, '{8'h86, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
            '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
            '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h7A, 1'b1, ZERO_FRAME_OK},
            // all-ones payload, bad checksum still yields a frame
            '{8'hFF, 1'b0, NO_FRAME}, '{8'h86, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
            '{8'hFF, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
            '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME}, '{8'h00, 1'b1, MAX_FRAME_BAD},
            // second start byte breaks the frame and is not taken as a new start
            '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME}, '{8'h86, 1'b0, NO_FRAME},
            '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME}, '{8'h00, 1'b0, NO_FRAME},
            '{8'h00, 1'b0, NO_FRAME}
        };

        cycle_count = 0;
        mismatch_count = 0;
        frame_bytes = 0;
        calm_phase = 1'b0;
        long_hold_req = 1'b0;
        shadow_pos = gsfp_pkg::POS_START;
        shadow_sum = 8'h00;
        shadow_gas = 8'h00;
        shadow_unit = 8'h00;
        shadow_conc_hi = 8'h00;
        shadow_conc_lo = 8'h00;
        cur_row = '0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_row(directed_rows[i], ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0);

        // Let the directed frames drain before random traffic
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge aclk);

        // Build random traffic: mostly good frames, some noise and broken frames
        while (frame_bytes < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                add_frame($urandom_range(0, 3) != 0);
            else if (pick < 85)
                add_broken_frame();
            else
                repeat ($urandom_range(1, 4)) begin
                    add_byte($urandom_range(0, 255));
                    frame_bytes++;
                end
        end

        quiet_left = 0;
        quiet = 1'b0;
        sent = 0;
        while (stim_q.size() != 0) begin
            row = stim_q.pop_front();
            calm_phase = (stim_q.size() < CALM_TAIL);
            if (quiet_left == 0) begin
                quiet = ($urandom_range(0, 2) == 0);
                quiet_left = 60;
            end
            quiet_left--;
            if (sent == 300)
                long_hold_req = 1'b1;
            if (sent == 700) begin
                // Pause until every frame in flight has come out
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (pending_frames.size() != 0)
                    @(posedge aclk);
            end
            gap = 0;
            if (!calm_phase && !quiet && $urandom_range(0, 7) == 0)
                gap = $urandom_range(1, 17);
            send_row(row, gap);
            sent++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/gsfp_pkg.sv
hdl/gsfp_in_reg.sv
hdl/gsfp_parser.sv
hdl/gas_sensor_frame_parser.sv
hdl/gsfp_checker.sv
dv/gas_sensor_frame_parser_tb.sv
